/* rtl/core/line_break_scanner_macros.svh */
// Assertion macros for the line break scanner checker.
// Each expects clk and rst_n in scope.
`ifndef LINE_BREAK_SCANNER_MACROS_SVH
`define LINE_BREAK_SCANNER_MACROS_SVH

// Same-cycle implication.
`define LBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lbs_pkg.sv */
package lbs_pkg;

    localparam int POS_BITS       = 48;
    localparam int CNT_BITS       = 48;
    localparam int CFG_DATA_BITS  = 48;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_STRIDE_MODE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_POSITION = 2'd1;

    localparam logic [1:0] MODE_LE16 = 2'd1;
    localparam logic [1:0] MODE_BE16 = 2'd2;

    localparam logic [15:0] UNIT_LF = 16'h000A;
    localparam logic [15:0] UNIT_CR = 16'h000D;

    typedef enum logic [1:0] {
        KIND_LF   = 2'd0,
        KIND_CRLF = 2'd1,
        KIND_CR   = 2'd2
    } break_kind_t;

    typedef struct packed {
        logic [POS_BITS-1:0] pos;
        logic [7:0]          held_byte;
        logic                held_valid;
        logic                cr_pend;
        logic [POS_BITS-1:0] cr_end;
        logic [CNT_BITS-1:0] lf_cnt;
    } scan_state_t;

    typedef struct packed {
        logic [POS_BITS-1:0] break_end;
        break_kind_t         kind;
        logic [CNT_BITS-1:0] lf_total;
        logic                last;
    } break_rec_t;

endpackage

/* rtl/core/lbs_step.sv */
// Per-byte scan step: unit assembly, CR/LF resolution, up to two breaks.
module lbs_step
    import lbs_pkg::*;
(
    input  logic [1:0]  stride_mode,
    input  scan_state_t cur,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output scan_state_t nxt,
    output logic [1:0]  rec_count,
    output break_rec_t  rec0,
    output break_rec_t  rec1
);

    logic [POS_BITS-1:0] end_pos;
    logic                wide;
    logic                have_unit;
    logic [15:0]         unit;
    logic                is_lf;
    logic                is_cr;
    logic [CNT_BITS-1:0] lf_new;
    logic                pend_mid;
    logic [POS_BITS-1:0] cr_end_mid;
    break_rec_t          cand_a;
    break_rec_t          cand_b;
    break_rec_t          cand_c;
    logic                vld_a;
    logic                vld_b;
    logic                vld_c;

    always_comb
    begin
        end_pos = (cur.pos != '1) ? cur.pos + POS_BITS'(1) : cur.pos;
        wide    = (stride_mode == MODE_LE16) || (stride_mode == MODE_BE16);

        nxt       = cur;
        nxt.pos   = end_pos;
        have_unit = 1'b0;
        unit      = '0;

        if (!wide)
        begin
            unit      = {8'h00, data_byte};
            have_unit = 1'b1;
        end
        else if (!cur.pos[0])
        begin
            nxt.held_byte  = data_byte;
            nxt.held_valid = 1'b1;
        end
        else if (cur.held_valid)
        begin
            unit           = (stride_mode == MODE_LE16) ? {data_byte, cur.held_byte}
                                                        : {cur.held_byte, data_byte};
            nxt.held_valid = 1'b0;
            have_unit      = 1'b1;
        end

        is_lf  = have_unit && (unit == UNIT_LF);
        is_cr  = have_unit && (unit == UNIT_CR);
        lf_new = (is_lf && (cur.lf_cnt != '1)) ? cur.lf_cnt + CNT_BITS'(1) : cur.lf_cnt;
        nxt.lf_cnt = lf_new;

        // pending CR resolved by this unit
        vld_a  = have_unit && cur.cr_pend;
        cand_a = '{break_end: is_lf ? end_pos : cur.cr_end,
                   kind:      is_lf ? KIND_CRLF : KIND_CR,
                   lf_total:  is_lf ? lf_new : cur.lf_cnt,
                   last:      1'b0};

        // unit on its own
        vld_b  = is_lf && !cur.cr_pend;
        cand_b = '{break_end: end_pos, kind: KIND_LF, lf_total: lf_new, last: 1'b0};

        pend_mid   = have_unit ? is_cr : cur.cr_pend;
        cr_end_mid = is_cr ? end_pos : cur.cr_end;

        // end-of-stream flush of a lone CR
        vld_c  = end_of_stream && pend_mid;
        cand_c = '{break_end: cr_end_mid, kind: KIND_CR, lf_total: lf_new, last: 1'b0};

        nxt.cr_pend = pend_mid && !end_of_stream;
        nxt.cr_end  = cr_end_mid;
        if (end_of_stream)
        begin
            nxt.held_valid = 1'b0;
            nxt.held_byte  = '0;
        end

        rec0 = cand_c;
        rec1 = cand_c;
        if (vld_a)
        begin
            rec0 = cand_a;
            rec1 = vld_b ? cand_b : cand_c;
        end
        else if (vld_b)
        begin
            rec0 = cand_b;
        end
        rec_count = 2'({1'b0, vld_a} + {1'b0, vld_b} + {1'b0, vld_c});
        rec0.last = (rec_count == 2'd1);
        rec1.last = 1'b1;
    end

endmodule

/* rtl/core/lbs_result_fifo.sv */
// Four-entry result queue, up to two pushes and one pop per cycle.
module lbs_result_fifo
    import lbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  break_rec_t push0,
    input  break_rec_t push1,
    input  logic       pop,
    output logic       room_for_two,
    output logic       head_valid,
    output break_rec_t head
);

    break_rec_t  entry_reg [4];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  wr_ptr_next;
    logic [1:0]  rd_ptr_reg;
    logic [1:0]  rd_ptr_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [1:0]  wr_ptr_plus;
    logic        do_pop;

    assign do_pop       = pop && (count_reg != 3'd0);
    assign head_valid   = (count_reg != 3'd0);
    assign head         = entry_reg[rd_ptr_reg];
    assign room_for_two = (count_reg <= 3'd2) || ((count_reg == 3'd3) && do_pop);
    assign wr_ptr_plus  = wr_ptr_reg + 2'd1;
    assign wr_ptr_next  = wr_ptr_reg + push_count;
    assign rd_ptr_next  = rd_ptr_reg + {1'b0, do_pop};
    assign count_next   = count_reg + {1'b0, push_count} - {2'b00, do_pop};

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_plus] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/line_break_scanner.sv */
// Line break scanner: takes one text byte per beat and reports every line
// terminator (LF, CRLF or lone CR) with the absolute position just past it,
// its kind and the running LF count. stride_mode picks byte units or 16-bit
// LE/BE units aligned to even absolute positions; start_position sets the
// position of the first byte. Any configuration write restarts the scan.
// Throughput is one byte per cycle. Only one case puts two beats on the
// result side for a single byte: a pending CR meets another CR unit that
// carries end_of_stream, so the first CR goes out as a lone CR and the second
// is flushed as a lone CR right behind it. The result side drains at one beat
// per cycle while break_ready is high. A byte passes through one input
// register, then the scan step writes into a four-entry result queue whose
// head drives the result ports. The input side stalls only when that queue
// cannot take two more results.
module line_break_scanner
    import lbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_write_enable,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // byte channel
    input  logic                      data_valid,
    output logic                      data_ready,
    input  logic [7:0]                data_byte,
    input  logic                      end_of_stream,
    // result channel
    output logic                      break_valid,
    input  logic                      break_ready,
    output logic [POS_BITS-1:0]       break_end,
    output logic [1:0]                break_kind,
    output logic [CNT_BITS-1:0]       lf_total,
    output logic                      run_last
);

    // configuration registers
    logic [1:0]          mode_reg;
    logic [POS_BITS-1:0] start_reg;

    // input register
    logic                in_vld_reg;
    logic [7:0]          in_byte_reg;
    logic                in_eos_reg;

    // scan state
    scan_state_t         state_reg;
    scan_state_t         state_next;
    scan_state_t         step_state;
    scan_state_t         restart_state;

    logic [1:0]          rec_count;
    break_rec_t          rec0;
    break_rec_t          rec1;
    logic                room_for_two;
    logic                fire;
    logic [1:0]          push_count;
    break_rec_t          head;
    logic                cfg_hit;
    logic [POS_BITS-1:0] start_new;

    // the step fires when a byte is held and the queue can take its worst case
    assign fire       = in_vld_reg && room_for_two;
    assign data_ready = !in_vld_reg || fire;
    assign push_count = fire ? rec_count : 2'd0;

    lbs_step u_step (
        .stride_mode   (mode_reg),
        .cur           (state_reg),
        .data_byte     (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .nxt           (step_state),
        .rec_count     (rec_count),
        .rec0          (rec0),
        .rec1          (rec1)
    );

    lbs_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (push_count),
        .push0        (rec0),
        .push1        (rec1),
        .pop          (break_ready),
        .room_for_two (room_for_two),
        .head_valid   (break_valid),
        .head         (head)
    );

    assign break_end  = head.break_end;
    assign break_kind = head.kind;
    assign lf_total   = head.lf_total;
    assign run_last   = head.last;

    // a write to either register restarts the scan from the (new) start position
    assign cfg_hit   = cfg_write_enable &&
                       ((cfg_index == CFG_STRIDE_MODE) || (cfg_index == CFG_START_POSITION));
    assign start_new = (cfg_index == CFG_START_POSITION) ? cfg_data[POS_BITS-1:0] : start_reg;

    always_comb
    begin
        restart_state            = '0;
        restart_state.pos        = start_new;
        if (cfg_hit)
        begin
            state_next = restart_state;
        end
        else if (fire)
        begin
            state_next = step_state;
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            start_reg  <= '0;
            state_reg  <= '0;
            in_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable && (cfg_index == CFG_STRIDE_MODE))
            begin
                mode_reg <= cfg_data[1:0];
            end
            if (cfg_write_enable && (cfg_index == CFG_START_POSITION))
            begin
                start_reg <= cfg_data[POS_BITS-1:0];
            end
            state_reg <= state_next;
            if (data_ready)
            begin
                in_vld_reg <= data_valid;
            end
        end
    end

    // byte payload; loaded on every accepted beat
    always_ff @(posedge clk)
    begin
        if (data_valid && data_ready)
        begin
            in_byte_reg <= data_byte;
            in_eos_reg  <= end_of_stream;
        end
    end

endmodule

/* rtl/core/lbs_checker.sv */
`include "line_break_scanner_macros.svh"

// Port-level checks for the line break scanner.
module lbs_checker
    import lbs_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_write_enable,
    input logic                      break_valid,
    input logic                      break_ready,
    input logic [POS_BITS-1:0]       break_end,
    input logic [1:0]                break_kind,
    input logic [CNT_BITS-1:0]       lf_total,
    input logic                      run_last
);

    logic [CNT_BITS-1:0] last_lf_reg;
    logic                out_beat;

    assign out_beat = break_valid && break_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_lf_reg <= '0;
        end
        else if (cfg_write_enable)
        begin
            last_lf_reg <= '0;
        end
        else if (out_beat)
        begin
            last_lf_reg <= lf_total;
        end
    end

    `LBS_ASSERT_NEXT(a_result_holds, break_valid && !break_ready,
                     break_valid && $stable(break_end) && $stable(break_kind) &&
                     $stable(lf_total) && $stable(run_last),
                     "result beat changed while stalled")
    `LBS_ASSERT_NOW(a_lf_monotonic, out_beat && !cfg_write_enable,
                    lf_total >= last_lf_reg, "LF count went backward")
    `LBS_ASSERT_NOW(a_lf_counted, break_valid && (break_kind != KIND_CR),
                    lf_total != '0, "LF break with zero LF count")
    `LBS_ASSERT_NOW(a_lf_end_nonzero, break_valid && (break_kind != KIND_CR),
                    break_end != '0, "LF break ends at position zero")

endmodule

bind line_break_scanner lbs_checker u_lbs_checker (.*);

/* sim/tb_top.sv */
module tb_top
    import lbs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Stride codes that the package does not name.
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Register indexes past the real ones; writes there must change nothing.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    // One input register ahead of a four-entry FIFO; SETTLE_CYCLES covers any
    // byte still in flight that yields nothing.
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_CYCLES  = 400;
    localparam int IDLE_PCT      = 19;

    logic                      clk;
    logic                      rst_n            = 1'b0;
    logic                      cfg_write_enable = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index        = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data         = '0;
    logic                      data_valid       = 1'b0;
    logic                      data_ready;
    logic [7:0]                data_byte        = '0;
    logic                      end_of_stream    = 1'b0;
    logic                      break_valid;
    logic                      break_ready      = 1'b0;
    logic [POS_BITS-1:0]       break_end;
    logic [1:0]                break_kind;
    logic [CNT_BITS-1:0]       lf_total;
    logic                      run_last;

    line_break_scanner u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .data_valid       (data_valid),
        .data_ready       (data_ready),
        .data_byte        (data_byte),
        .end_of_stream    (end_of_stream),
        .break_valid      (break_valid),
        .break_ready      (break_ready),
        .break_end        (break_end),
        .break_kind       (break_kind),
        .lf_total         (lf_total),
        .run_last         (run_last)
    );

    // ------------------------------------------------------------------
    // Scanner shadow state: mirrors what the block should hold
    // ------------------------------------------------------------------
    logic [1:0]          unit_mode;
    logic [POS_BITS-1:0] start_reg;
    logic [POS_BITS-1:0] scan_pos;
    logic [7:0]          held_byte_q;
    logic                held_q;
    logic                cr_wait;
    logic [POS_BITS-1:0] cr_end_q;
    logic [CNT_BITS-1:0] lf_seen;

    break_rec_t pending_breaks[$];

    // Run bookkeeping
    int  mismatches   = 0;
    int  bytes_sent   = 0;
    int  stall_bytes  = 0;
    int  reg_writes   = 0;
    int  kinds_checked[3];
    bit  calm         = 1'b0;   // no idling on either side while set
    int  hold_cycles  = 0;      // receiver hold-off, counted down below

    function automatic void restart_scan();
        scan_pos    = start_reg;
        held_byte_q = '0;
        held_q      = 1'b0;
        cr_wait     = 1'b0;
        cr_end_q    = '0;
        lf_seen     = '0;
    endfunction

    function automatic break_rec_t make_break(input logic [POS_BITS-1:0] at,
                                              input break_kind_t kind);
        break_rec_t rec;
        rec.break_end = at;
        rec.kind      = kind;
        rec.lf_total  = lf_seen;
        rec.last      = 1'b0;
        return rec;
    endfunction

    // One accepted byte: advance the shadow state and queue the breaks it
    // closes, in output order, with the last one flagged.
    function automatic void scan_byte(input logic [7:0] b, input logic eos);
        logic [POS_BITS-1:0] here;
        logic [POS_BITS-1:0] past;
        logic                wide;
        logic                got_unit;
        logic [15:0]         unit;
        logic                paired;
        break_rec_t          found[2];
        int                  n;
        here     = scan_pos;
        past     = (here == POS_MAX) ? POS_MAX : here + 1'b1;
        wide     = (unit_mode == MODE_LE16) || (unit_mode == MODE_BE16);
        got_unit = 1'b0;
        unit     = '0;
        paired   = 1'b0;
        n        = 0;
        scan_pos = past;

        if (!wide) begin
            unit     = {8'h00, b};
            got_unit = 1'b1;
        end else if (!here[0]) begin
            held_byte_q = b;
            held_q      = 1'b1;
        end else if (held_q) begin
            // odd byte completes the unit; an odd byte with nothing held drops
            unit     = (unit_mode == MODE_LE16) ? {b, held_byte_q} : {held_byte_q, b};
            held_q   = 1'b0;
            got_unit = 1'b1;
        end

        if (got_unit) begin
            if (cr_wait) begin
                cr_wait = 1'b0;
                if (unit == UNIT_LF) begin
                    if (lf_seen != CNT_MAX) lf_seen = lf_seen + 1'b1;
                    found[n] = make_break(past, KIND_CRLF);
                    n++;
                    paired = 1'b1;
                end else begin
                    found[n] = make_break(cr_end_q, KIND_CR);
                    n++;
                end
            end
            if (!paired) begin
                if (unit == UNIT_LF) begin
                    if (lf_seen != CNT_MAX) lf_seen = lf_seen + 1'b1;
                    found[n] = make_break(past, KIND_LF);
                    n++;
                end else if (unit == UNIT_CR) begin
                    cr_wait  = 1'b1;
                    cr_end_q = past;
                end
            end
        end

        if (eos) begin
            if (cr_wait) begin
                cr_wait  = 1'b0;
                found[n] = make_break(cr_end_q, KIND_CR);
                n++;
            end
            held_q      = 1'b0;
            held_byte_q = '0;
        end

        for (int i = 0; i < n; i++) begin
            if (i == n - 1) found[i].last = 1'b1;
            pending_breaks.push_back(found[i]);
        end
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                break_ready <= 1'b0;
                hold_cycles--;
            end else begin
                break_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare every result beat against the oldest queued break.
    initial begin
        break_rec_t want;
        forever begin
            @(posedge clk);
            if (rst_n && break_valid && break_ready) begin
                if (pending_breaks.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat end=%0h kind=%0d lf=%0d last=%0b",
                                            break_end, break_kind, lf_total, run_last));
                end else begin
                    want = pending_breaks.pop_front();
                    if (break_end !== want.break_end || break_kind !== want.kind ||
                        lf_total !== want.lf_total || run_last !== want.last) begin
                        note_mismatch($sformatf(
                            "end %0h/%0h kind %0d/%0d lf %0d/%0d last %0b/%0b (exp/got)",
                            want.break_end, break_end, want.kind, break_kind,
                            want.lf_total, lf_total, want.last, run_last));
                    end
                    kinds_checked[want.kind]++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one byte; valid stays up between back-to-back beats.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            data_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        data_valid    <= 1'b1;
        data_byte     <= b;
        end_of_stream <= eos;
        do @(posedge clk); while (!data_ready);
        scan_byte(b, eos);
        bytes_sent++;
    endtask

    // Drop valid, let every predicted break drain, then let the pipe settle.
    task automatic wait_idle();
        data_valid <= 1'b0;
        do @(posedge clk); while (pending_breaks.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= value;
        @(posedge clk);
        case (idx)
            CFG_STRIDE_MODE: begin
                unit_mode = value[1:0];
                restart_scan();
            end
            CFG_START_POSITION: begin
                start_reg = value[POS_BITS-1:0];
                restart_scan();
            end
            default: ;
        endcase
        reg_writes++;
        cfg_write_enable <= 1'b0;
        @(posedge clk);
    endtask

    // Stride write carries random junk above bit 1; the block must mask it.
    task automatic configure(input logic [1:0] mode, input logic [POS_BITS-1:0] start);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        junk[1:0] = mode;
        wait_idle();
        write_reg(CFG_STRIDE_MODE, junk[CFG_DATA_BITS-1:0]);
        write_reg(CFG_START_POSITION, start);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 22) return CH_LF;
        if (r < 42) return CH_CR;
        return 8'($urandom_range(255));
    endfunction

    // Wide units: real terminators, some byte-swapped near misses, the rest random.
    function automatic logic [15:0] pick_unit();
        int r;
        r = $urandom_range(99);
        if (r < 22) return UNIT_LF;
        if (r < 42) return UNIT_CR;
        if (r < 47) return {CH_LF, 8'h00};
        if (r < 52) return {CH_CR, 8'h00};
        return 16'($urandom);
    endfunction

    // Random text in the current mode. In wide modes units are sent on
    // aligned pairs; a stray byte now and then breaks the pairing.
    task automatic random_stream(input int n_items);
        int          sent;
        logic [15:0] unit;
        sent = 0;
        while (sent < n_items) begin
            if (unit_mode == MODE_LE16 || unit_mode == MODE_BE16) begin
                if (scan_pos[0] || $urandom_range(99) < 5) begin
                    send_byte(8'($urandom_range(255)), $urandom_range(99) < 3);
                    sent++;
                end else begin
                    unit = pick_unit();
                    send_byte((unit_mode == MODE_LE16) ? unit[7:0] : unit[15:8],
                              $urandom_range(99) < 2);
                    send_byte((unit_mode == MODE_LE16) ? unit[15:8] : unit[7:0],
                              $urandom_range(99) < 3);
                    sent += 2;
                end
            end else begin
                send_byte(pick_byte(), $urandom_range(99) < 3);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset config: byte units from position 0. LF, CRLF, CR before a
    // non-LF, CR before CR, and a CR closing the stream behind a lone CR
    // (two beats from one byte).
    task automatic test_byte_terminators();
        send_byte(8'h00, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_CR, 1'b1);
    endtask

    // 16-bit units: odd leading byte skipped, CRLF across units, trailing
    // byte-swapped CR at end of stream is no break; BE lone CR then CRLF.
    task automatic test_wide_units();
        configure(MODE_LE16, 48'd1);
        send_byte(CH_LF, 1'b0);          // odd position, nothing held: ignored
        send_byte(CH_CR, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_CR, 1'b1);          // odd position, completes a byte-swapped CR unit at end: no break
        configure(MODE_BE16, 48'd0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_LF, 1'b1);
    endtask

    // Stride code 3 behaves as bytes; writes to spare indexes must not
    // restart the scan, so a CR held across them still pairs with the LF.
    task automatic test_spare_mode_and_index();
        configure(MODE_SPARE, 48'd5);
        send_byte(CH_CR, 1'b0);
        wait_idle();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '0);
        send_byte(CH_LF, 1'b1);
    endtask

    // Receiver holds off for a long stretch while LFs keep coming: the
    // result queue fills and data_ready must drop until it drains.
    task automatic test_output_stall();
        configure(MODE_BYTE, 48'd100);
        hold_cycles = STALL_CYCLES;
        for (int i = 0; i < 60; i++) begin
            send_byte((i % 3 == 2) ? CH_CR : CH_LF, 1'b0);
            stall_bytes++;
        end
        send_byte(8'h20, 1'b1);
        stall_bytes++;
    endtask

    // Random phases over every stride code, start at 0, at the top and
    // close enough to it that positions saturate, plus one calm stretch.
    task automatic test_random_streams();
        logic [63:0] r;
        configure(MODE_BYTE, 48'd0);
        random_stream(300);

        r = {$urandom, $urandom};
        r[0] = 1'b1;
        configure(MODE_LE16, r[POS_BITS-1:0]);
        random_stream(250);

        configure(MODE_BYTE, POS_MAX - 48'd150);
        random_stream(250);

        configure(MODE_BE16, POS_MAX - 48'd60);
        random_stream(100);

        r = {$urandom, $urandom};
        configure(MODE_SPARE, r[POS_BITS-1:0]);
        random_stream(250);

        r = {$urandom, $urandom};
        configure(MODE_LE16, r[POS_BITS-1:0]);
        calm = 1'b1;
        random_stream(300);
        wait_idle();
        calm = 1'b0;

        r = {$urandom, $urandom};
        configure(MODE_BE16, r[POS_BITS-1:0]);
        random_stream(200);

        configure(MODE_BYTE, POS_MAX);
        random_stream(60);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        unit_mode = MODE_BYTE;
        start_reg = '0;
        restart_scan();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_byte_terminators();
        test_wide_units();
        test_spare_mode_and_index();
        test_output_stall();
        test_random_streams();
        wait_idle();

        $display("Scanned %0d bytes across %0d register writes %s",
                 bytes_sent, reg_writes, "(byte, LE16, BE16, code 3; start 0..max).");
        $display("Checked %0d LF, %0d CRLF, %0d lone CR beats;",
                 kinds_checked[KIND_LF], kinds_checked[KIND_CRLF], kinds_checked[KIND_CR]);
        $display("%0d bytes pushed into a %0d-cycle stall.", stall_bytes, STALL_CYCLES);
        if (mismatches == 0 && pending_breaks.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
